/* rtl/core/sorted_priority_queue_defines.svh */
// assertion macros for the port checker
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, reset masked
`define SPQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted priority queue check failed");

// next-cycle implication, reset masked
`define SPQ_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted priority queue check failed");

`endif

/* rtl/core/spq_pkg.sv */
// types, codes and defaults of the sorted priority queue
package spq_pkg;

	localparam int DEPTH_DEF = 16;

	localparam logic [1:0] CMD_ENQ  = 2'd0;
	localparam logic [1:0] CMD_DEQ  = 2'd1;
	localparam logic [1:0] CMD_PEEK = 2'd2;
	localparam logic [1:0] CMD_DUMP = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] prio;
	} entry_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] value;
		logic signed [31:0] prio;
		logic               last;
	} res_t;

endpackage

/* rtl/core/spq_ifs.sv */
// request and response channel interfaces
interface spq_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic signed [31:0] item_value;
	logic signed [31:0] item_priority;

	modport source (output valid, command, item_value, item_priority, input ready);
	modport sink (input valid, command, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] out_value;
	logic signed [31:0] out_priority;
	logic               last;

	modport source (output valid, status, out_value, out_priority, last, input ready);
	modport sink (input valid, status, out_value, out_priority, last, output ready);
endinterface

/* rtl/core/sorted_priority_queue.sv */
// Sorted priority queue of up to DEPTH (data, priority) entries held in a ring-addressed
// memory, head first, larger priority first, equal priorities in arrival order. The block
// takes one command at a time. An enqueue into a queue that is neither empty nor full uses
// a single compare unit that walks from the tail toward the head, one entry per cycle,
// moving each stored entry of lower priority a place back through the one memory read
// port and one write port. A dump gives one result per stored entry. Empty-queue requests
// give a single result; a full-queue enqueue is dropped. No clearing pass is needed
// after reset. The next command is taken while the last result still sits in the
// output register.
module sorted_priority_queue #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(DEPTH);

	logic                res_valid;
	logic                res_ready;
	spq_pkg::res_t       res;
	spq_pkg::entry_t     req_entry;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	spq_pkg::entry_t     ram_wdata;
	logic [IDX_W-1:0]    ram_raddr;
	spq_pkg::entry_t     ram_rdata;
	logic                rsp_valid_q;
	spq_pkg::res_t       rsp_q;

	assign req_entry.value = req.item_value;
	assign req_entry.prio  = req.item_priority;

	spq_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_ready   (req.ready),
		.req_command (req.command),
		.req_entry   (req_entry),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

	spq_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register
	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_q.status;
	assign rsp.out_value    = rsp_q.value;
	assign rsp.out_priority = rsp_q.prio;
	assign rsp.last         = rsp_q.last;

endmodule

/* rtl/core/spq_ram.sv */
// entry store, one write port and one registered read port
module spq_ram #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  spq_pkg::entry_t            wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output spq_pkg::entry_t            rdata
);

	spq_pkg::entry_t mem_q [DEPTH];
	spq_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/spq_seq.sv */
// command sequencer with the shared priority compare and ring addressing
module spq_seq #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  logic [1:0]               req_command,
	input  spq_pkg::entry_t          req_entry,
	output logic                     res_valid,
	input  logic                     res_ready,
	output spq_pkg::res_t            res,
	output logic                     ram_we,
	output logic [$clog2(DEPTH)-1:0] ram_waddr,
	output spq_pkg::entry_t          ram_wdata,
	output logic [$clog2(DEPTH)-1:0] ram_raddr,
	input  spq_pkg::entry_t          ram_rdata
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_PUTNEW = 3'd2;
	localparam logic [2:0] S_READ   = 3'd3;
	localparam logic [2:0] S_EMIT   = 3'd4;

	logic [2:0]          state_q;
	logic [1:0]          cmd_q;
	spq_pkg::entry_t     new_q;
	logic [IDX_W-1:0]    head_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    k_q;
	spq_pkg::res_t       res_q;

	logic [IDX_W-1:0]    tail_k;
	logic [IDX_W-1:0]    k_inc;
	logic [IDX_W-1:0]    k_dec;
	logic [IDX_W-1:0]    head_inc;
	logic                full;
	logic                empty;
	logic                stop;

	// logical position to ring address
	function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
		input logic [IDX_W-1:0] k);
		logic [IDX_W:0] s;
		s = {1'b0, head} + {1'b0, k};
		if (s >= (IDX_W+1)'(DEPTH)) begin
			s = s - (IDX_W+1)'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	assign tail_k   = IDX_W'(count_q - CNT_W'(1));
	assign k_inc    = k_q + IDX_W'(1);
	assign k_dec    = k_q - IDX_W'(1);
	assign head_inc = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	// stored entry keeps its place ahead of the new one
	assign stop     = ($signed(ram_rdata.prio) >= $signed(new_q.prio));

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_EMIT);
	assign res       = res_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = phys(head_q, k_inc);
		ram_wdata = new_q;
		ram_raddr = phys(head_q, k_q);
		unique case (state_q)
			S_IDLE: begin
				if (req_command == spq_pkg::CMD_ENQ) begin
					ram_raddr = phys(head_q, tail_k);
					ram_waddr = head_q;
					ram_wdata = req_entry;
					ram_we    = req_valid && empty;
				end else begin
					ram_raddr = head_q;
				end
			end
			S_SCAN: begin
				ram_we = 1'b1;
				if (!stop) begin
					ram_wdata = ram_rdata;
					ram_raddr = phys(head_q, k_dec);
				end
			end
			S_PUTNEW: begin
				ram_we    = 1'b1;
				ram_waddr = head_q;
			end
			S_EMIT: begin
				ram_raddr = phys(head_q, k_inc);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						if (req_command == spq_pkg::CMD_ENQ) begin
							if (full) begin
								state_q <= S_EMIT;
							end else if (empty) begin
								count_q <= count_q + CNT_W'(1);
								state_q <= S_EMIT;
							end else begin
								k_q     <= tail_k;
								state_q <= S_SCAN;
							end
						end else if (empty) begin
							state_q <= S_EMIT;
						end else begin
							k_q     <= '0;
							state_q <= S_READ;
						end
					end
				end
				S_SCAN: begin
					if (stop) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_EMIT;
					end else if (k_q == '0) begin
						state_q <= S_PUTNEW;
					end else begin
						k_q <= k_dec;
					end
				end
				S_PUTNEW: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_EMIT;
				end
				S_READ: begin
					if (cmd_q == spq_pkg::CMD_DEQ) begin
						head_q  <= head_inc;
						count_q <= count_q - CNT_W'(1);
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (res_ready) begin
						if (cmd_q == spq_pkg::CMD_DUMP && !res_q.last) begin
							k_q     <= k_inc;
							state_q <= S_READ;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command, new entry and pending result
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			cmd_q        <= req_command;
			new_q        <= req_entry;
			res_q.value  <= '0;
			res_q.prio   <= '0;
			res_q.last   <= 1'b1;
			if (req_command == spq_pkg::CMD_ENQ) begin
				res_q.status <= full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
			end else begin
				res_q.status <= empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
			end
		end else if (state_q == S_READ) begin
			res_q.status <= spq_pkg::ST_OK;
			res_q.value  <= ram_rdata.value;
			res_q.prio   <= (cmd_q == spq_pkg::CMD_DEQ) ? '0 : ram_rdata.prio;
			res_q.last   <= (cmd_q != spq_pkg::CMD_DUMP) || (k_q == tail_k);
		end
	end

endmodule

/* rtl/core/spq_checker.sv */
// port checker for the sorted priority queue and its bind
`include "sorted_priority_queue_defines.svh"

module spq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic [31:0] rsp_value,
	input logic [31:0] rsp_priority,
	input logic        rsp_last
);

	logic status_known;
	logic zero_last;

	assign status_known = (rsp_status == spq_pkg::ST_OK) || (rsp_status == spq_pkg::ST_EMPTY)
		|| (rsp_status == spq_pkg::ST_FULL);
	assign zero_last = rsp_last && (rsp_value == 32'd0) && (rsp_priority == 32'd0);

	// stalled result stays offered
	`SPQ_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

	`SPQ_ASSERT_IMP(a_status_code, rsp_valid, status_known)

	// empty and full results are single, zero results
	`SPQ_ASSERT_IMP(a_err_single, rsp_valid && rsp_status != spq_pkg::ST_OK, zero_last)

	// one command at a time
	`SPQ_ASSERT_NXT(a_one_cmd, req_valid && req_ready, !req_ready)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_value    (rsp.out_value),
	.rsp_priority (rsp.out_priority),
	.rsp_last     (rsp.last)
);
